/* rtl/scm_pkg.sv */
// ----------------------------------------------------------------------------
// scm_pkg
// shared types, constants and helpers for the snapshot compare memory scan
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int SNAPSHOT_BYTES = 65536;
    localparam int LANES          = 8;
    localparam int LANE_W         = $clog2(LANES);
    localparam int LANE_DEPTH     = SNAPSHOT_BYTES / LANES;
    localparam int ROW_W          = $clog2(LANE_DEPTH);
    localparam int ADDR_W         = 16;
    localparam int VALUE_W        = 64;
    localparam int COUNT_W        = 17;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // register indexes on the configuration port
    localparam logic [2:0] REG_SIZE_CODE      = 3'd0;
    localparam logic [2:0] REG_IS_UNSIGNED    = 3'd1;
    localparam logic [2:0] REG_RELATION       = 3'd2;
    localparam logic [2:0] REG_USE_CONSTANT   = 3'd3;
    localparam logic [2:0] REG_CONSTANT_VALUE = 3'd4;

    // window widths
    localparam logic [1:0] SIZE_1 = 2'd0;
    localparam logic [1:0] SIZE_2 = 2'd1;
    localparam logic [1:0] SIZE_4 = 2'd2;
    localparam logic [1:0] SIZE_8 = 2'd3;

    typedef enum logic [2:0] {
        REL_EQ = 3'd0,
        REL_GT = 3'd1,
        REL_LT = 3'd2,
        REL_GE = 3'd3,
        REL_LE = 3'd4,
        REL_NE = 3'd5
    } rel_t;

    typedef struct packed {
        logic [1:0]         size_code;
        logic               is_unsigned;
        logic [2:0]         relation;
        logic               use_constant;
        logic signed [31:0] constant_value;
    } cfg_t;

    function automatic logic [VALUE_W-1:0] window_mask(input logic [1:0] size_code);
        logic [VALUE_W-1:0] m;
        unique case (size_code)
            SIZE_1:  m = 64'h0000_0000_0000_00FF;
            SIZE_2:  m = 64'h0000_0000_0000_FFFF;
            SIZE_4:  m = 64'h0000_0000_FFFF_FFFF;
            SIZE_8:  m = 64'hFFFF_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // maps a window value to a key whose unsigned order is the chosen order
    function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] v,
                                                     input logic [1:0] size_code,
                                                     input logic is_unsigned);
        logic [VALUE_W-1:0] m;
        logic [VALUE_W-1:0] sign;
        m    = window_mask(size_code);
        sign = m ^ (m >> 1);
        return is_unsigned ? (v & m) : ((v & m) ^ sign);
    endfunction

endpackage

/* rtl/scm_ram.sv */
// ----------------------------------------------------------------------------
// scm_ram
// generic single-write, single-read ram with registered read (read-first)
// ----------------------------------------------------------------------------
module scm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/scm_regs.sv */
// ----------------------------------------------------------------------------
// scm_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module scm_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scm_pkg::PADDR_W-1:0]  paddr,
    input  logic [scm_pkg::PDATA_W-1:0]  pwdata,
    output logic [scm_pkg::PDATA_W-1:0]  prdata,
    output scm_pkg::cfg_t                cfg
);

    scm_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                scm_pkg::REG_SIZE_CODE:      cfg_reg.size_code      <= pwdata[1:0];
                scm_pkg::REG_IS_UNSIGNED:    cfg_reg.is_unsigned    <= pwdata[0];
                scm_pkg::REG_RELATION:       cfg_reg.relation       <= pwdata[2:0];
                scm_pkg::REG_USE_CONSTANT:   cfg_reg.use_constant   <= pwdata[0];
                scm_pkg::REG_CONSTANT_VALUE: cfg_reg.constant_value <= pwdata;
                default:                     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            scm_pkg::REG_SIZE_CODE:      prdata = {30'd0, cfg_reg.size_code};
            scm_pkg::REG_IS_UNSIGNED:    prdata = {31'd0, cfg_reg.is_unsigned};
            scm_pkg::REG_RELATION:       prdata = {29'd0, cfg_reg.relation};
            scm_pkg::REG_USE_CONSTANT:   prdata = {31'd0, cfg_reg.use_constant};
            scm_pkg::REG_CONSTANT_VALUE: prdata = cfg_reg.constant_value;
            default:                     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/snapshot_compare_memory_scan.sv */
// ----------------------------------------------------------------------------
// snapshot_compare_memory_scan
// memory-scan value filter over a byte snapshot store
//
// input channel (in_valid / in_stall) brings mode, first_of_pass, address and
// mem_value; output channel (out_valid / out_stall) returns matched,
// match_address, old_value, match_total and next_address, one result per item.
// the snapshot lives in eight byte-lane rams of 8192 rows each; a window of up
// to eight bytes touches every lane at most once, so the new window is written
// and the old one read in the accept cycle, and the compare runs on the
// registered read data the cycle after.
// items pass from the read stage to the output register. throughput: one item
// per cycle while out_stall is low, set by the single read and write port
// of each lane ram. a stalled result sits in the output register while the
// next item waits in the read stage; in_stall rises only when both are full.
// reset clears the pipeline valids, the match count and the registers; the
// snapshot contents are undefined until written. pready is always high.
// ----------------------------------------------------------------------------
module snapshot_compare_memory_scan (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scm_pkg::PADDR_W-1:0]  paddr,
    input  logic [scm_pkg::PDATA_W-1:0]  pwdata,
    output logic [scm_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    // input items
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic                         first_of_pass,
    input  logic [scm_pkg::ADDR_W-1:0]   address,
    input  logic [scm_pkg::VALUE_W-1:0]  mem_value,
    // result items
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         matched,
    output logic [scm_pkg::ADDR_W-1:0]   match_address,
    output logic [scm_pkg::VALUE_W-1:0]  old_value,
    output logic [scm_pkg::COUNT_W-1:0]  match_total,
    output logic [scm_pkg::COUNT_W-1:0]  next_address
);

    localparam int LANES  = scm_pkg::LANES;
    localparam int LANE_W = scm_pkg::LANE_W;
    localparam int ROW_W  = scm_pkg::ROW_W;

    scm_pkg::cfg_t cfg;

    logic in_accept;
    logic out_load;
    logic s1_adv;

    logic [ROW_W-1:0]  lane_row   [LANES];
    logic              lane_we    [LANES];
    logic [7:0]        lane_wdata [LANES];
    logic [7:0]        lane_rdata [LANES];
    logic [LANE_W-1:0] lane_off   [LANES];
    logic [LANE_W:0]   nbytes;

    // read stage
    logic                         s1_valid_reg;
    logic                         s1_mode_reg;
    logic                         s1_first_reg;
    logic [scm_pkg::ADDR_W-1:0]   s1_addr_reg;
    logic [scm_pkg::VALUE_W-1:0]  s1_cur_reg;

    // compare
    logic [scm_pkg::VALUE_W-1:0]  old_full;
    logic [scm_pkg::VALUE_W-1:0]  old_win;
    logic [scm_pkg::VALUE_W-1:0]  ref_val;
    logic [scm_pkg::VALUE_W-1:0]  key_a;
    logic [scm_pkg::VALUE_W-1:0]  key_b;
    logic                         rel_eq;
    logic                         rel_gt;
    logic                         rel_hold;
    logic                         hit;
    logic [scm_pkg::COUNT_W-1:0]  count_clr;
    logic [scm_pkg::COUNT_W-1:0]  count_next;
    logic [scm_pkg::COUNT_W-1:0]  next_addr;

    // output stage and count
    logic                         out_valid_reg;
    logic                         matched_reg;
    logic [scm_pkg::ADDR_W-1:0]   match_address_reg;
    logic [scm_pkg::VALUE_W-1:0]  old_value_reg;
    logic [scm_pkg::COUNT_W-1:0]  match_total_reg;
    logic [scm_pkg::COUNT_W-1:0]  next_address_reg;
    logic [scm_pkg::COUNT_W-1:0]  count_reg;

    scm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // handshake
    assign out_load  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_load;
    assign in_stall  = s1_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;

    assign nbytes = (LANE_W+1)'(1) << cfg.size_code;

    // lane addressing: byte k of the window sits in lane (address + k) mod 8
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_off[l]   = LANE_W'(l) - address[LANE_W-1:0];
            lane_we[l]    = in_accept && ({1'b0, lane_off[l]} < nbytes);
            lane_wdata[l] = mem_value[8*lane_off[l] +: 8];
            if (LANE_W'(l) >= address[LANE_W-1:0])
            begin
                lane_row[l] = address[scm_pkg::ADDR_W-1:LANE_W];
            end
            else
            begin
                lane_row[l] = address[scm_pkg::ADDR_W-1:LANE_W] + ROW_W'(1);
            end
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        scm_ram #(
            .WIDTH (8),
            .DEPTH (scm_pkg::LANE_DEPTH)
        ) u_lane (
            .clk   (clk),
            .we    (lane_we[g]),
            .waddr (lane_row[g]),
            .wdata (lane_wdata[g]),
            .re    (in_accept),
            .raddr (lane_row[g]),
            .rdata (lane_rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg  <= mode;
            s1_first_reg <= first_of_pass;
            s1_addr_reg  <= address;
            s1_cur_reg   <= mem_value;
        end
    end

    // gather the old window back into byte order
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            old_full[8*k +: 8] = lane_rdata[s1_addr_reg[LANE_W-1:0] + LANE_W'(k)];
        end
    end

    assign old_win = s1_mode_reg ? (old_full & scm_pkg::window_mask(cfg.size_code)) : '0;
    assign ref_val = cfg.use_constant ?
                     {{32{cfg.constant_value[31]}}, cfg.constant_value} : old_win;
    assign key_a   = scm_pkg::order_key(s1_cur_reg, cfg.size_code, cfg.is_unsigned);
    assign key_b   = scm_pkg::order_key(ref_val, cfg.size_code, cfg.is_unsigned);
    assign rel_eq  = key_a == key_b;
    assign rel_gt  = key_a > key_b;

    always_comb
    begin
        unique case (cfg.relation)
            scm_pkg::REL_EQ: rel_hold = rel_eq;
            scm_pkg::REL_GT: rel_hold = rel_gt;
            scm_pkg::REL_LT: rel_hold = !rel_gt && !rel_eq;
            scm_pkg::REL_GE: rel_hold = rel_gt || rel_eq;
            scm_pkg::REL_LE: rel_hold = !rel_gt;
            default:         rel_hold = !rel_eq;
        endcase
    end

    assign hit        = s1_mode_reg && rel_hold;
    assign count_clr  = s1_first_reg ? '0 : count_reg;
    assign count_next = (hit && (count_clr != scm_pkg::COUNT_MAX)) ?
                        count_clr + scm_pkg::COUNT_W'(1) : count_clr;
    assign next_addr  = {1'b0, s1_addr_reg} +
                        (hit ? scm_pkg::COUNT_W'(nbytes) : scm_pkg::COUNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            matched_reg       <= hit;
            match_address_reg <= s1_addr_reg;
            old_value_reg     <= old_win;
            match_total_reg   <= count_next;
            next_address_reg  <= next_addr;
        end
    end

    assign out_valid     = out_valid_reg;
    assign matched       = matched_reg;
    assign match_address = match_address_reg;
    assign old_value     = old_value_reg;
    assign match_total   = match_total_reg;
    assign next_address  = next_address_reg;

endmodule
